@@ rtl/pwt_pkg.sv @@
// Shared types, widths and codes of the path window tracker.
package pwt_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int RAD_W      = SQ_W + 2;
    localparam int LEN_W      = RAD_W / 2;
    localparam int ACC_W      = LEN_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_IDX_W  = 10;

    typedef logic [1:0] op_t;
    localparam op_t OP_CLEAR    = 2'd0;
    localparam op_t OP_APPEND   = 2'd1;
    localparam op_t OP_ACTIVATE = 2'd2;
    localparam op_t OP_QUERY    = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t STAT_CROP     = 3'd0;
    localparam status_t STAT_END      = 3'd1;
    localparam status_t STAT_ORIGIN   = 3'd2;
    localparam status_t STAT_INACTIVE = 3'd3;
    localparam status_t STAT_ACCEPTED = 3'd4;
    localparam status_t STAT_OVERFLOW = 3'd5;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_WINDOW_SIZE    = 4'd0;
    localparam cfg_idx_t REG_BACKTRACK_STEP = 4'd1;
    localparam cfg_idx_t REG_WINDOW_THRESH  = 4'd2;
    localparam cfg_idx_t REG_TRIM_LIMIT     = 4'd3;
    localparam cfg_idx_t REG_BACKTRACK_TOL  = 4'd4;
    localparam cfg_idx_t REG_LOOKAHEAD      = 4'd5;
    localparam cfg_idx_t REG_ORIGIN_CANCEL  = 4'd6;
    localparam cfg_idx_t REG_MODE_FLAGS     = 4'd7;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;

    // request to the length unit
    typedef struct packed {
        logic  start;
        diff_t dx;
        diff_t dy;
    } len_req_t;

    // answer of the length unit
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
    } len_rsp_t;

endpackage

@@ rtl/pwt_req_if.sv @@
// Input request channel of the path window tracker.
interface pwt_req_if;
    import pwt_pkg::*;
    logic   valid;
    logic   ready;
    op_t    operation;
    coord_t pos_x;
    coord_t pos_y;
    logic [OUT_IDX_W-1:0] start_index;
    modport source (output valid, operation, pos_x, pos_y, start_index, input ready);
    modport sink (input valid, operation, pos_x, pos_y, start_index, output ready);
endinterface

@@ rtl/pwt_rsp_if.sv @@
// Result channel of the path window tracker.
interface pwt_rsp_if;
    import pwt_pkg::*;
    logic    valid;
    logic    ready;
    status_t status;
    logic [OUT_IDX_W-1:0] nearest_index;
    logic [OUT_IDX_W-1:0] crop_start;
    logic [OUT_IDX_W-1:0] crop_end;
    modport source (output valid, status, nearest_index, crop_start, crop_end, input ready);
    modport sink (input valid, status, nearest_index, crop_start, crop_end, output ready);
endinterface

@@ rtl/pwt_cfg_if.sv @@
// Configuration write channel of the path window tracker.
interface pwt_cfg_if;
    import pwt_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pwt_ram.sv @@
// Generic single write, single read RAM with registered read data.
module pwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/pwt_len.sv @@
// Euclidean length unit: squares, then a bit-serial integer square root.
module pwt_len (
    input  logic              clk,
    input  logic              rst_n,
    input  pwt_pkg::len_req_t req,
    output pwt_pkg::len_rsp_t rsp
);
    import pwt_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_SQ   = 4'b0010,
        L_SUM  = 4'b0100,
        L_ITER = 4'b1000
    } lstate_t;

    localparam int CNT_BITS = $clog2(LEN_W);

    lstate_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic [DIFF_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [SQ_W-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [RAD_W-1:0]  rad_reg, rad_next, res_reg, res_next, bit_reg, bit_next;
    logic [RAD_W-1:0]  trial;

    assign trial = res_reg + bit_reg;

    // sequence squares and root iterations
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        rad_next   = rad_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    ax_next    = req.dx[DIFF_W-1] ? DIFF_W'(-req.dx) : DIFF_W'(req.dx);
                    ay_next    = req.dy[DIFF_W-1] ? DIFF_W'(-req.dy) : DIFF_W'(req.dy);
                    state_next = L_SQ;
                end
            end
            L_SQ:
            begin
                sx_next    = ax_reg * ax_reg;
                sy_next    = ay_reg * ay_reg;
                state_next = L_SUM;
            end
            L_SUM:
            begin
                rad_next   = RAD_W'(sx_reg) + RAD_W'(sy_reg);
                res_next   = '0;
                bit_next   = RAD_W'(1) << (RAD_W - 2);
                cnt_next   = CNT_BITS'(LEN_W - 1);
                state_next = L_ITER;
            end
            L_ITER:
            begin
                if (rad_reg >= trial)
                begin
                    rad_next = rad_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        rad_reg <= rad_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.len  = res_reg[LEN_W-1:0];
endmodule

@@ rtl/path_window_tracker.sv @@
// Top level of the path window tracker: path store, sequencer and result register.
// Clear, append and activate: the result is registered as the request is taken.
// A query visits points one at a time (RAM read, squares and the 26-step root
// in the length unit): window, optional whole path, trim and look-ahead walks.
// One request at a time.
// Reset clears control state and loads register defaults; the path store is
// undefined until appended.
module path_window_tracker (
    input  logic clk,
    input  logic rst_n,
    pwt_req_if.sink   req,
    pwt_rsp_if.source rsp,
    pwt_cfg_if.sink   cfg
);
    import pwt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ORG   = 9'b000000010,
        S_SETUP = 9'b000000100,
        S_RD    = 9'b000001000,
        S_DAT   = 9'b000010000,
        S_LEN   = 9'b000100000,
        S_POST  = 9'b001000000,
        S_HOLD  = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        PH_WIN  = 2'd0,
        PH_GLOB = 2'd1,
        PH_TRIM = 2'd2,
        PH_LOOK = 2'd3
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [IDX_W-1:0] idx_reg, idx_next, last_reg, last_next, ms_reg, ms_next;
    logic [IDX_W-1:0] best_reg, best_next, raw_reg, raw_next, fin_reg, fin_next;
    logic [IDX_W-1:0] cend_reg, cend_next;
    logic [CNT_W-1:0] count_reg, count_next, wend_reg, wend_next;
    logic active_reg, active_next, found_reg, found_next, pre_reg, pre_next;
    logic [LEN_W-1:0] bestd_reg, bestd_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    coord_t px_reg, px_next, py_reg, py_next;
    coord_t prx_reg, prx_next, pry_reg, pry_next, cx_reg, cx_next, cy_reg, cy_next;

    logic [10:0] ws_reg;
    logic [9:0]  bs_reg, tol_reg;
    logic [19:0] thr_reg, trim_reg, look_reg, org_reg;
    logic [1:0]  mode_reg;

    logic    ov_reg, ov_next;
    status_t st_reg, st_next;
    logic [OUT_IDX_W-1:0] on_reg, on_next, os_reg, os_next, oe_reg, oe_next;
    status_t rs_reg, rs_next;
    logic [IDX_W-1:0] rn_reg, rn_next, rcs_reg, rcs_next, rce_reg, rce_next;

    len_req_t len_req;
    len_rsp_t len_rsp;

    logic ram_we;
    logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;
    coord_t rd_x, rd_y;

    logic slot_free, take;
    logic [CNT_W-1:0] idx_inc, wend_raw, lim;
    logic [IDX_W-1:0] wstart;
    logic better;
    logic [LEN_W-1:0] nbd;
    logic [IDX_W-1:0] nb;
    logic [ACC_W-1:0] acc_sum;

    assign slot_free = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign take      = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rd_x    = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_y    = ram_rdata[COORD_BITS-1:0];
    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign lim     = (phase_reg == PH_WIN) ? wend_reg : count_reg;
    assign better  = !found_reg || (len_rsp.len < bestd_reg);
    assign nbd     = better ? len_rsp.len : bestd_reg;
    assign nb      = better ? idx_reg : best_reg;
    assign acc_sum = acc_reg + ACC_W'(len_rsp.len);
    assign wstart  = (last_reg > bs_reg) ? last_reg - bs_reg : '0;
    assign wend_raw = CNT_W'({1'b0, last_reg} + {1'b0, ws_reg});

    // path store, x in the upper half
    pwt_ram #(
        .WIDTH(2 * COORD_BITS),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[IDX_W-1:0]),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    pwt_len u_len (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (len_req),
        .rsp  (len_rsp)
    );

    assign ram_wdata = {req.pos_x, req.pos_y};

    // sequence requests through the path store
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        ms_next     = ms_reg;
        best_next   = best_reg;
        raw_next    = raw_reg;
        fin_next    = fin_reg;
        cend_next   = cend_reg;
        count_next  = count_reg;
        wend_next   = wend_reg;
        active_next = active_reg;
        found_next  = found_reg;
        pre_next    = pre_reg;
        bestd_next  = bestd_reg;
        acc_next    = acc_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        prx_next    = prx_reg;
        pry_next    = pry_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rs_next     = rs_reg;
        rn_next     = rn_reg;
        rcs_next    = rcs_reg;
        rce_next    = rce_reg;
        ov_next     = ov_reg && !rsp.ready;
        st_next     = st_reg;
        on_next     = on_reg;
        os_next     = os_reg;
        oe_next     = oe_reg;
        ram_we      = 1'b0;
        len_req.start = 1'b0;
        len_req.dx    = diff_t'(rd_x) - diff_t'(px_reg);
        len_req.dy    = diff_t'(rd_y) - diff_t'(py_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                len_req.dx = diff_t'(req.pos_x);
                len_req.dy = diff_t'(req.pos_y);
                if (take)
                begin
                    ov_next = 1'b1;
                    st_next = STAT_ACCEPTED;
                    on_next = '0;
                    os_next = '0;
                    oe_next = '0;
                    px_next = req.pos_x;
                    py_next = req.pos_y;
                    case (req.operation)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            last_next   = '0;
                            ms_next     = '0;
                            active_next = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg >= CNT_W'(MAX_POINTS))
                            begin
                                st_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_ACTIVATE:
                        begin
                            last_next   = IDX_W'(req.start_index);
                            ms_next     = IDX_W'(req.start_index);
                            active_next = 1'b1;
                        end
                        default:
                        begin
                            if (!active_reg)
                            begin
                                st_next = STAT_INACTIVE;
                            end
                            else if (count_reg == '0)
                            begin
                                active_next = 1'b0;
                                st_next     = STAT_END;
                                on_next     = OUT_IDX_W'(last_reg);
                            end
                            else
                            begin
                                // the result comes later
                                ov_next = 1'b0;
                                if (mode_reg[1])
                                begin
                                    len_req.start = 1'b1;
                                    state_next    = S_ORG;
                                end
                                else
                                begin
                                    state_next = S_SETUP;
                                end
                            end
                        end
                    endcase
                end
            end
            S_ORG:
            begin
                if (len_rsp.done)
                begin
                    if (len_rsp.len <= LEN_W'(org_reg))
                    begin
                        active_next = 1'b0;
                        rs_next     = STAT_ORIGIN;
                        rn_next     = last_reg;
                        rcs_next    = '0;
                        rce_next    = '0;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                // pick the window, or the whole path if it is empty
                found_next = 1'b0;
                state_next = S_RD;
                pre_next   = 1'b0;
                wend_next  = (wend_raw > count_reg) ? count_reg : wend_raw;
                if ({1'b0, wstart} < ((wend_raw > count_reg) ? count_reg : wend_raw))
                begin
                    phase_next = PH_WIN;
                    idx_next   = wstart;
                end
                else
                begin
                    phase_next = PH_GLOB;
                    idx_next   = '0;
                end
            end
            S_RD:
            begin
                state_next = S_DAT;
            end
            S_DAT:
            begin
                if (pre_reg)
                begin
                    // load the segment's first point
                    prx_next   = rd_x;
                    pry_next   = rd_y;
                    pre_next   = 1'b0;
                    idx_next   = idx_inc[IDX_W-1:0];
                    state_next = S_RD;
                end
                else
                begin
                    if (phase_reg == PH_TRIM || phase_reg == PH_LOOK)
                    begin
                        len_req.dx = diff_t'(rd_x) - diff_t'(prx_reg);
                        len_req.dy = diff_t'(rd_y) - diff_t'(pry_reg);
                    end
                    cx_next       = rd_x;
                    cy_next       = rd_y;
                    len_req.start = 1'b1;
                    state_next    = S_LEN;
                end
            end
            S_LEN:
            begin
                if (len_rsp.done)
                begin
                    case (phase_reg)
                        PH_WIN, PH_GLOB:
                        begin
                            best_next  = nb;
                            bestd_next = nbd;
                            found_next = 1'b1;
                            if (idx_inc < lim)
                            begin
                                idx_next   = idx_inc[IDX_W-1:0];
                                state_next = S_RD;
                            end
                            else if (phase_reg == PH_WIN && nbd >= LEN_W'(thr_reg))
                            begin
                                phase_next = PH_GLOB;
                                found_next = 1'b0;
                                idx_next   = '0;
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_POST;
                            end
                        end
                        PH_TRIM:
                        begin
                            if (acc_sum > ACC_W'(trim_reg))
                            begin
                                state_next = S_HOLD;
                            end
                            else
                            begin
                                acc_next = acc_sum;
                                raw_next = idx_reg;
                                prx_next = cx_reg;
                                pry_next = cy_reg;
                                if (idx_inc < count_reg)
                                begin
                                    idx_next   = idx_inc[IDX_W-1:0];
                                    state_next = S_RD;
                                end
                                else
                                begin
                                    state_next = S_HOLD;
                                end
                            end
                        end
                        default:
                        begin
                            acc_next = acc_sum;
                            prx_next = cx_reg;
                            pry_next = cy_reg;
                            rs_next  = STAT_CROP;
                            rn_next  = best_reg;
                            rcs_next = fin_reg;
                            rce_next = cend_reg;
                            if (acc_sum >= ACC_W'(look_reg))
                            begin
                                rce_next   = idx_reg;
                                state_next = S_FIN;
                            end
                            else if (idx_inc < count_reg)
                            begin
                                idx_next   = idx_inc[IDX_W-1:0];
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_POST:
            begin
                last_next = best_reg;
                raw_next  = best_reg;
                acc_next  = '0;
                if (count_reg < CNT_W'(2) || ({1'b0, best_reg} + CNT_W'(2)) >= count_reg
                    || look_reg == '0)
                begin
                    active_next = 1'b0;
                    rs_next     = STAT_END;
                    rn_next     = best_reg;
                    rcs_next    = '0;
                    rce_next    = '0;
                    state_next  = S_FIN;
                end
                else if (mode_reg[0])
                begin
                    phase_next = PH_TRIM;
                    idx_next   = best_reg;
                    pre_next   = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                // hold the start against small backtracks, then clamp it
                if (raw_reg > ms_reg)
                begin
                    ms_next  = raw_reg;
                    fin_next = raw_reg;
                end
                else if ((ms_reg - raw_reg) <= tol_reg)
                begin
                    fin_next = ms_reg;
                end
                else
                begin
                    ms_next  = raw_reg;
                    fin_next = raw_reg;
                end
                if (({1'b0, fin_next} + 1'b1) >= count_reg)
                begin
                    fin_next = IDX_W'(count_reg - CNT_W'(2));
                end
                phase_next = PH_LOOK;
                acc_next   = '0;
                cend_next  = IDX_W'(count_reg - 1'b1);
                idx_next   = fin_next;
                pre_next   = 1'b1;
                state_next = S_RD;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    st_next    = rs_reg;
                    on_next    = OUT_IDX_W'(rn_reg);
                    os_next    = OUT_IDX_W'(rcs_reg);
                    oe_next    = OUT_IDX_W'(rce_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            last_reg   <= '0;
            ms_reg     <= '0;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
            ws_reg     <= 11'd120;
            bs_reg     <= 10'd8;
            thr_reg    <= 20'd2458;
            trim_reg   <= 20'd614;
            tol_reg    <= 10'd5;
            look_reg   <= 20'd12288;
            org_reg    <= 20'd1229;
            mode_reg   <= 2'd1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
            ms_reg     <= ms_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_WINDOW_SIZE:    ws_reg   <= cfg.data[10:0];
                    REG_BACKTRACK_STEP: bs_reg   <= cfg.data[9:0];
                    REG_WINDOW_THRESH:  thr_reg  <= cfg.data;
                    REG_TRIM_LIMIT:     trim_reg <= cfg.data;
                    REG_BACKTRACK_TOL:  tol_reg  <= cfg.data[9:0];
                    REG_LOOKAHEAD:      look_reg <= cfg.data;
                    REG_ORIGIN_CANCEL:  org_reg  <= cfg.data;
                    REG_MODE_FLAGS:     mode_reg <= cfg.data[1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        raw_reg   <= raw_next;
        fin_reg   <= fin_next;
        cend_reg  <= cend_next;
        wend_reg  <= wend_next;
        found_reg <= found_next;
        pre_reg   <= pre_next;
        bestd_reg <= bestd_next;
        acc_reg   <= acc_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        prx_reg   <= prx_next;
        pry_reg   <= pry_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        rs_reg    <= rs_next;
        rn_reg    <= rn_next;
        rcs_reg   <= rcs_next;
        rce_reg   <= rce_next;
        st_reg    <= st_next;
        on_reg    <= on_next;
        os_reg    <= os_next;
        oe_reg    <= oe_next;
    end

    assign rsp.valid         = ov_reg;
    assign rsp.status        = st_reg;
    assign rsp.nearest_index = on_reg;
    assign rsp.crop_start    = os_reg;
    assign rsp.crop_end      = oe_reg;

`ifndef SYNTHESIS
    a_len_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        len_rsp.done |-> (state_reg == S_LEN || state_reg == S_ORG))
        else $error("length result outside a waiting state");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");
    a_crop_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && st_reg == STAT_CROP) |-> (os_reg < oe_reg))
        else $error("crop start not below crop end");
    a_crop_keeps_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && slot_free && rs_reg == STAT_CROP) |=> active_reg)
        else $error("tracking dropped on a crop result");
`endif
endmodule

@@ verif/tb_path_window_tracker.sv @@
// Testbench of the path window tracker: scoreboard with crop predictor and stimulus.
`timescale 1ns / 1ps

module tb_path_window_tracker;
    import pwt_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;

    typedef struct {
        status_t              status;
        logic [OUT_IDX_W-1:0] nearest_index;
        logic [OUT_IDX_W-1:0] crop_start;
        logic [OUT_IDX_W-1:0] crop_end;
    } crop_result_t;

    // Mirror of the tracker state; predicts one result per request.
    class crop_scoreboard;
        longint          path_x [MAX_POINTS];
        longint          path_y [MAX_POINTS];
        int unsigned     point_count;
        int unsigned     last_nearest;
        int unsigned     max_start;
        bit              tracking;
        int unsigned     reg_val [8];
        crop_result_t    pending_crops [$];
        int              error_count;

        function new();
            reg_val = '{120, 8, 2458, 614, 5, 12288, 1229, 1};
            point_count = 0;
            last_nearest = 0;
            max_start = 0;
            tracking = 0;
            error_count = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, int unsigned value);
            int unsigned widths [8];
            widths = '{11, 10, 20, 20, 10, 20, 20, 2};
            if (idx < 8)
                reg_val[idx] = value & ((32'd1 << widths[idx]) - 1);
        endfunction

        function longint unsigned root_of(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint unsigned span_len(longint dx, longint dy);
            longint unsigned ax, ay, sx, sy, s;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            sx = ax * ax;
            sy = ay * ay;
            s = sx + sy;
            if (s < sx) s = 64'hFFFF_FFFF_FFFF_FFFF;
            return root_of(s);
        endfunction

        function longint unsigned seg(int unsigned a, int unsigned b);
            return span_len(path_x[b] - path_x[a], path_y[b] - path_y[a]);
        endfunction

        function crop_result_t predict_crop(op_t op, coord_t px_in, coord_t py_in,
                                            logic [OUT_IDX_W-1:0] start_idx);
            crop_result_t r;
            longint px, py;
            longint unsigned bestd, d, acc;
            int unsigned n, i, best, wstart, wend, raw, fin, cend;
            bit found;
            px = px_in;
            py = py_in;
            n = point_count;
            r = '{STAT_ACCEPTED, 0, 0, 0};
            found = 0;
            bestd = 0;
            case (op)
                OP_CLEAR:
                begin
                    point_count = 0;
                    last_nearest = 0;
                    max_start = 0;
                    tracking = 0;
                    return r;
                end
                OP_APPEND:
                begin
                    if (n >= MAX_POINTS)
                        r.status = STAT_OVERFLOW;
                    else
                    begin
                        path_x[n] = px;
                        path_y[n] = py;
                        point_count = n + 1;
                    end
                    return r;
                end
                OP_ACTIVATE:
                begin
                    last_nearest = start_idx;
                    max_start = start_idx;
                    tracking = 1;
                    return r;
                end
                default: ;
            endcase
            if (!tracking)
            begin
                r.status = STAT_INACTIVE;
                return r;
            end
            if (n == 0)
            begin
                tracking = 0;
                r.status = STAT_END;
                r.nearest_index = last_nearest;
                return r;
            end
            if (reg_val[REG_MODE_FLAGS][1] && span_len(px, py) <= reg_val[REG_ORIGIN_CANCEL])
            begin
                tracking = 0;
                r.status = STAT_ORIGIN;
                r.nearest_index = last_nearest;
                return r;
            end
            // window search, then the whole path when it misses
            wstart = (last_nearest > reg_val[REG_BACKTRACK_STEP]) ?
                     last_nearest - reg_val[REG_BACKTRACK_STEP] : 0;
            wend = last_nearest + reg_val[REG_WINDOW_SIZE];
            if (wend > n) wend = n;
            best = last_nearest;
            for (i = wstart; i < wend; i++)
            begin
                d = span_len(path_x[i] - px, path_y[i] - py);
                if (!found || d < bestd)
                begin
                    bestd = d;
                    best = i;
                    found = 1;
                end
            end
            if (!found || bestd >= reg_val[REG_WINDOW_THRESH])
            begin
                found = 0;
                for (i = 0; i < n; i++)
                begin
                    d = span_len(path_x[i] - px, path_y[i] - py);
                    if (!found || d < bestd)
                    begin
                        bestd = d;
                        best = i;
                        found = 1;
                    end
                end
            end
            last_nearest = best;
            r.nearest_index = best;
            if (n < 2 || best >= n - 2 || reg_val[REG_LOOKAHEAD] == 0)
            begin
                tracking = 0;
                r.status = STAT_END;
                return r;
            end
            // advance the start by up to the trim distance when mode bit 0 is set
            raw = best;
            if (reg_val[REG_MODE_FLAGS][0])
            begin
                acc = 0;
                for (i = best; i + 1 < n; i++)
                begin
                    d = seg(i, i + 1);
                    if (acc + d > reg_val[REG_TRIM_LIMIT]) break;
                    acc += d;
                    raw = i + 1;
                end
            end
            // hold the start against small backtracks
            if (raw > max_start)
            begin
                max_start = raw;
                fin = raw;
            end
            else if (max_start - raw <= reg_val[REG_BACKTRACK_TOL])
                fin = max_start;
            else
            begin
                max_start = raw;
                fin = raw;
            end
            if (fin >= n - 1) fin = n - 2;
            // walk the end forward to the look-ahead length
            acc = 0;
            cend = n - 1;
            for (i = fin + 1; i < n; i++)
            begin
                acc += seg(i - 1, i);
                if (acc >= reg_val[REG_LOOKAHEAD])
                begin
                    cend = i;
                    break;
                end
            end
            r.status = STAT_CROP;
            r.crop_start = fin;
            r.crop_end = cend;
            return r;
        endfunction

        function void note_request(op_t op, coord_t px, coord_t py,
                                   logic [OUT_IDX_W-1:0] start_idx);
            pending_crops = {pending_crops, predict_crop(op, px, py, start_idx)};
        endfunction

        function void check_result(crop_result_t got);
            crop_result_t exp_r;
            if (pending_crops.size() == 0)
            begin
                $error("result with no request pending: status %0d", got.status);
                error_count++;
                return;
            end
            exp_r = pending_crops.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                error_count++;
            end
            if (got.nearest_index !== exp_r.nearest_index)
            begin
                $error("nearest_index: expected %0d, got %0d",
                       exp_r.nearest_index, got.nearest_index);
                error_count++;
            end
            if (got.crop_start !== exp_r.crop_start)
            begin
                $error("crop_start: expected %0d, got %0d", exp_r.crop_start, got.crop_start);
                error_count++;
            end
            if (got.crop_end !== exp_r.crop_end)
            begin
                $error("crop_end: expected %0d, got %0d", exp_r.crop_end, got.crop_end);
                error_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    pwt_req_if req_ch ();
    pwt_rsp_if rsp_ch ();
    pwt_cfg_if cfg_ch ();

    path_window_tracker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    crop_scoreboard sb;
    int  burst_left;
    int  hold_off;
    int  idle_cycles;
    longint walk_x, walk_y;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count cycles with no handshake on any channel; end a hung run.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receive results; stall on a pattern of shifting density, or hold off on request.
    initial
    begin : receiver
        int mode;
        int mode_left;
        crop_result_t got;
        mode = 0;
        mode_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.nearest_index = rsp_ch.nearest_index;
                got.crop_start = rsp_ch.crop_start;
                got.crop_end = rsp_ch.crop_end;
                sb.check_result(got);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 80);
            end
            mode_left--;
            if (hold_off > 0)
            begin
                hold_off--;
                rsp_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                rsp_ch.ready <= 1'b1;
            else if (mode == 1)
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                rsp_ch.ready <= ($urandom_range(0, 5) == 0);
        end
    end

    // Offer one request; idle between bursts of random length.
    task automatic send_request(op_t op, coord_t px, coord_t py, logic [OUT_IDX_W-1:0] sidx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.pos_x <= px;
        req_ch.pos_y <= py;
        req_ch.start_index <= sidx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, px, py, sidx);
    endtask

    // Lower valid and wait until every result has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_crops.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic write_all(int unsigned v0, int unsigned v1, int unsigned v2,
                             int unsigned v3, int unsigned v4, int unsigned v5,
                             int unsigned v6, int unsigned v7);
        drain();
        write_reg(REG_WINDOW_SIZE, v0);
        write_reg(REG_BACKTRACK_STEP, v1);
        write_reg(REG_WINDOW_THRESH, v2);
        write_reg(REG_TRIM_LIMIT, v3);
        write_reg(REG_BACKTRACK_TOL, v4);
        write_reg(REG_LOOKAHEAD, v5);
        write_reg(REG_ORIGIN_CANCEL, v6);
        write_reg(REG_MODE_FLAGS, v7);
    endtask

    // Clear and lay down a path of n points as a random walk.
    task automatic build_path(int n);
        send_request(OP_CLEAR, coord_t'($urandom), coord_t'($urandom), OUT_IDX_W'($urandom));
        walk_x = $signed($urandom_range(0, 4000000)) - 2000000;
        walk_y = $signed($urandom_range(0, 4000000)) - 2000000;
        repeat (n)
        begin
            walk_x += $signed($urandom_range(0, 12000)) - 3000;
            walk_y += $signed($urandom_range(0, 12000)) - 6000;
            send_request(OP_APPEND, coord_t'(walk_x), coord_t'(walk_y), OUT_IDX_W'($urandom));
        end
    endtask

    // Query near a stored point, with some noise.
    task automatic query_near(int idx);
        longint qx, qy;
        qx = sb.path_x[idx] + $signed($urandom_range(0, 3000)) - 1500;
        qy = sb.path_y[idx] + $signed($urandom_range(0, 3000)) - 1500;
        send_request(OP_QUERY, coord_t'(qx), coord_t'(qy), OUT_IDX_W'($urandom));
    endtask

    initial
    begin : stimulus
        int n, k, pos;
        sb = new();
        burst_left = 0;
        hold_off = 0;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.operation <= OP_CLEAR;
        req_ch.pos_x <= '0;
        req_ch.pos_y <= '0;
        req_ch.start_index <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: inactive, empty path, extremes, end reached, start beyond path
        send_request(OP_QUERY, 24'sh7FFFFF, 24'sh800000, 10'd0);
        send_request(OP_ACTIVATE, 0, 0, 10'd1023);
        send_request(OP_QUERY, 0, 0, 0);
        send_request(OP_APPEND, 24'sh7FFFFF, 24'sh7FFFFF, 0);
        send_request(OP_APPEND, 24'sh800000, 24'sh800000, 10'h3FF);
        send_request(OP_ACTIVATE, 0, 0, 10'd0);
        send_request(OP_QUERY, 24'sh7FFFFF, 24'sh800000, 0);
        send_request(OP_CLEAR, 0, 0, 0);
        for (k = 0; k < 8; k++)
            send_request(OP_APPEND, coord_t'(k * 2048), 0, 0);
        send_request(OP_ACTIVATE, 0, 0, 10'd1000);
        query_near(1);
        query_near(3);
        query_near(2);
        query_near(7);
        send_request(OP_ACTIVATE, 0, 0, 10'd0);
        send_request(OP_QUERY, 10, 10, 0);
        write_all(1024, 1023, 0, 0, 0, 0, 0, 2);
        send_request(OP_ACTIVATE, 0, 0, 10'd0);
        query_near(2);
        send_request(OP_ACTIVATE, 0, 0, 10'd0);
        send_request(OP_QUERY, 100, -100, 0);
        write_all(1, 0, 20'hFFFFF, 20'hFFFFF, 1023, 20'hFFFFF, 20'hFFFFF, 1);
        send_request(OP_ACTIVATE, 0, 0, 10'd4);
        query_near(0);
        query_near(5);

        // long receiver hold-off while requests keep coming
        drain();
        hold_off = 400;
        build_path(12);

        // longer path: narrow window, then a jump that forces the whole-path search
        write_all(8, 4, 2458, 614, 5, 12288, 1229, 1);
        build_path(30);
        send_request(OP_APPEND, 5, 5, 0);
        send_request(OP_APPEND, -5, -5, 0);
        send_request(OP_ACTIVATE, 0, 0, 10'd20);
        query_near(25);
        query_near(2);

        // random phases with random settings
        for (int phase = 0; phase < 6; phase++)
        begin
            write_all($urandom_range(1, 1024), $urandom_range(0, 1023),
                      ($urandom_range(0, 1)) ? $urandom_range(0, 20000) :
                                               $urandom_range(0, 20'hFFFFF),
                      ($urandom_range(0, 1)) ? $urandom_range(0, 20000) :
                                               $urandom_range(0, 20'hFFFFF),
                      $urandom_range(0, 1023),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF) :
                                                    $urandom_range(0, 30000),
                      ($urandom_range(0, 1)) ? $urandom_range(0, 3000) :
                                               $urandom_range(0, 20'hFFFFF),
                      $urandom_range(0, 3));
            n = $urandom_range(2, 20);
            build_path(n);
            send_request(OP_ACTIVATE, 0, 0,
                         OUT_IDX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) :
                                                                  $urandom_range(0, 3)));
            pos = 0;
            repeat (8)
            begin
                k = $urandom_range(0, 9);
                if (k < 6)
                begin
                    pos = pos + $urandom_range(0, 2) - ((k == 0) ? 2 : 0);
                    if (pos < 0) pos = 0;
                    if (pos > n - 1) pos = n - 1;
                    query_near(pos);
                end
                else if (k == 6)
                    send_request(OP_QUERY, coord_t'($urandom), coord_t'($urandom),
                                 OUT_IDX_W'($urandom));
                else if (k == 7)
                    send_request(OP_QUERY, coord_t'($signed($urandom_range(0, 2000)) - 1000),
                                 coord_t'($signed($urandom_range(0, 2000)) - 1000), 0);
                else if (k == 8)
                    send_request(OP_ACTIVATE, coord_t'($urandom), coord_t'($urandom),
                                 OUT_IDX_W'($urandom_range(0, n + 2)));
                else
                    send_request(op_t'($urandom_range(0, 3)), coord_t'($urandom),
                                 coord_t'($urandom), OUT_IDX_W'($urandom));
            end
        end

        // pause until every result is back, then finish on default settings
        drain();
        write_all(120, 8, 2458, 614, 5, 12288, 1229, 1);
        build_path(6);
        send_request(OP_ACTIVATE, 0, 0, 10'd0);
        query_near(1);
        query_near(2);
        drain();
        repeat (100) @(posedge clk);
        if (sb.error_count == 0 && sb.pending_crops.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
